FILE: rtl/u8d_pkg.sv
// Package: shared types, constants and identifier-class functions for the UTF-8 decoder.
`default_nettype none

package u8d_pkg;

   localparam int CP_W = 21;

   localparam logic OP_DATA = 1'b0;
   localparam logic OP_END  = 1'b1;

   localparam int RSP_DEPTH = 4;
   localparam int CONT_RANGES = 31;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            valid_res;
      logic            ident_start;
      logic            ident_continue;
      logic            last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]      bytes_pending;
      logic [2:0]      seq_length;
      logic [CP_W-1:0] value_accum;
      logic            skipping;
   } state_type;

   localparam logic [CP_W-1:0] CONT_LO [CONT_RANGES] = '{
      21'h000A8, 21'h000AA, 21'h000AD, 21'h000AF, 21'h000B2, 21'h000B7, 21'h000BC,
      21'h000C0, 21'h000D8, 21'h000F8, 21'h00100, 21'h01681, 21'h0180F, 21'h0200B,
      21'h0202A, 21'h0203F, 21'h02054, 21'h02060, 21'h02070, 21'h02460, 21'h02776,
      21'h02C00, 21'h02E80, 21'h03004, 21'h03021, 21'h03031, 21'h03040, 21'h0F900,
      21'h0FD40, 21'h0FDF0, 21'h0FE47
   };

   localparam logic [CP_W-1:0] CONT_HI [CONT_RANGES] = '{
      21'h000A8, 21'h000AA, 21'h000AD, 21'h000AF, 21'h000B5, 21'h000BA, 21'h000BE,
      21'h000D6, 21'h000F6, 21'h000FF, 21'h0167F, 21'h0180D, 21'h01FFF, 21'h0200D,
      21'h0202E, 21'h02040, 21'h02054, 21'h0206F, 21'h0218F, 21'h024FF, 21'h02793,
      21'h02DFF, 21'h02FFF, 21'h03007, 21'h0302F, 21'h0303F, 21'h0D7FF, 21'h0FD3D,
      21'h0FDCF, 21'h0FE44, 21'h0FFF8
   };

   function automatic logic ident_cont_f(input logic [CP_W-1:0] c);
      logic hit;
      hit = 1'b0;
      if (c < 21'h80) begin
         hit = c inside {[21'h61:21'h7A], [21'h41:21'h5A], [21'h30:21'h39], 21'h5F, 21'h24};
      end else begin
         for (int i = 0; i < CONT_RANGES; i++) begin
            if (c >= CONT_LO[i] && c <= CONT_HI[i]) begin
               hit = 1'b1;
            end
         end
         // planes 1..14, all but the last two code points of each plane
         if (c >= 21'h10000 && c <= 21'hEFFFD && c[15:0] <= 16'hFFFD) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

   function automatic logic ident_start_f(input logic [CP_W-1:0] c);
      logic excl;
      excl = (c inside {[21'h30:21'h39], 21'h24}) ||
             (c inside {[21'h0300:21'h036F], [21'h1DC0:21'h1DFF],
                        [21'h20D0:21'h20FF], [21'hFE20:21'hFE2F]});
      return ident_cont_f(c) && !excl;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/u8d_if.sv
// Interfaces: byte request channel and decoded-character response channel.
`default_nettype none

interface u8d_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] byte_value;

   modport source (output valid, output op, output byte_value, input ready);
   modport sink   (input valid, input op, input byte_value, output ready);
endinterface

interface u8d_rsp_if;
   logic        valid;
   logic        ready;
   logic [20:0] code_point;
   logic        valid_res;
   logic        ident_start;
   logic        ident_continue;
   logic        last;

   modport source (output valid, output code_point, output valid_res,
                   output ident_start, output ident_continue, output last,
                   input ready);
   modport sink   (input valid, input code_point, input valid_res,
                   input ident_start, input ident_continue, input last,
                   output ready);
endinterface

`default_nettype wire

FILE: rtl/utf8_decode_ident_classify.sv
// Top level: UTF-8 byte stream decoder with identifier-class tagging.
// A byte is decoded from the input register; its results are written into the response queue.
// Throughput: one byte per cycle while the queue has room; rsp presents one result per transfer.
// The input register drains while the 4-entry response queue holds two or fewer results.
// Reset (synchronous, active high) clears decoder state, the input register and the queue.
`default_nettype none

module utf8_decode_ident_classify import u8d_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   u8d_req_if.sink  req_if,
   u8d_rsp_if.source rsp_if
);

   // Input register: holds one accepted transaction until the queue has room
   logic       stg_valid_ff;
   logic       stg_valid_in;
   logic       stg_op_ff;
   logic [7:0] stg_byte_ff;
   logic       stg_drain;
   logic       req_take;
   logic       room;

   // Running decoder state: partial sequence and resync flag
   state_type  state_ff;
   state_type  state_next;

   logic [1:0] res_count;
   logic [1:0] wr_count;
   rsp_type    res0;
   rsp_type    res1;

   // Advance the stage whenever the queue can take two more results
   assign stg_drain    = stg_valid_ff && room;
   assign req_if.ready = !stg_valid_ff || room;
   assign req_take     = req_if.valid && req_if.ready;
   assign stg_valid_in = req_take || (stg_valid_ff && !stg_drain);

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         if (stg_drain) begin
            state_ff <= state_next;
         end
      end
   end

   // Payload capture: no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         stg_op_ff   <= req_if.op;
         stg_byte_ff <= req_if.byte_value;
      end
   end

   u8d_decode u_decode (
      .state      (state_ff),
      .op         (stg_op_ff),
      .byte_value (stg_byte_ff),
      .state_next (state_next),
      .res_count  (res_count),
      .res0       (res0),
      .res1       (res1)
   );

   // Push results only on the cycle the stage drains
   assign wr_count = stg_drain ? res_count : 2'd0;

   u8d_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_count (wr_count),
      .wr_data0 (res0),
      .wr_data1 (res1),
      .room     (room),
      .rsp_if   (rsp_if)
   );

   // A pending count always lies below the sequence length it belongs to
   a_pending_below_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff.bytes_pending != 2'd0) |->
         ({1'b0, state_ff.bytes_pending} < state_ff.seq_length))
      else $error("pending count not below sequence length");

   // Resync mode never overlaps an open sequence
   a_skip_no_seq: assert property (@(posedge clock) disable iff (reset)
      state_ff.skipping |-> (state_ff.bytes_pending == 2'd0))
      else $error("skipping while a sequence is open");

   // An end marker leaves the decoder fully cleared
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (stg_drain && stg_op_ff == OP_END) |=> (state_ff == '0))
      else $error("state not cleared after end marker");

   // Error results carry no code point and no classes
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.valid_res) |->
         (rsp_if.code_point == '0 && !rsp_if.ident_start && !rsp_if.ident_continue))
      else $error("error result with nonzero payload");

   // Start class implies continue class
   a_start_in_cont: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.ident_start) |-> rsp_if.ident_continue)
      else $error("ident_start without ident_continue");

endmodule

`default_nettype wire

FILE: rtl/u8d_decode.sv
// Decode step: next decoder state and up to two results for one byte or end marker.
`default_nettype none

module u8d_decode import u8d_pkg::*; (
   input  state_type  state,
   input  logic       op,
   input  logic [7:0] byte_value,
   output state_type  state_next,
   output logic [1:0] res_count,
   output rsp_type    res0,
   output rsp_type    res1
);

   logic            start_byte;
   logic            cont_byte;
   logic            lead_emit;
   logic            lead_ok;
   logic [2:0]      lead_len;
   logic [CP_W-1:0] lead_accum;
   logic [CP_W-1:0] fin_value;
   logic [2:0]      fin_need;
   logic            fin_ok;
   logic [CP_W-1:0] cls_cp;
   logic            cls_start;
   logic            cls_cont;
   rsp_type         err_res;
   rsp_type         lead_res;
   rsp_type         fin_res;
   state_type       lead_state;

   assign start_byte = (byte_value < 8'h80) || (byte_value inside {[8'hC2:8'hF4]});
   assign cont_byte  = byte_value inside {[8'h80:8'hBF]};

   // Lead byte outcome
   always_comb begin
      lead_emit  = (byte_value < 8'h80) || !start_byte;
      lead_ok    = byte_value < 8'h80;
      if (byte_value[7:5] == 3'b110) begin
         lead_len   = 3'd2;
         lead_accum = {16'd0, byte_value[4:0]};
      end else if (byte_value[7:4] == 4'b1110) begin
         lead_len   = 3'd3;
         lead_accum = {17'd0, byte_value[3:0]};
      end else begin
         lead_len   = 3'd4;
         lead_accum = {18'd0, byte_value[2:0]};
      end
      lead_state = '0;
      if (!lead_emit) begin
         lead_state.seq_length    = lead_len;
         lead_state.bytes_pending = lead_len[1:0] - 2'd1;
         lead_state.value_accum   = lead_accum;
      end
      lead_state.skipping = !start_byte;
   end

   // Sequence completion check
   always_comb begin
      fin_value = {state.value_accum[CP_W-7:0], byte_value[5:0]};
      if (fin_value < 21'h800) begin
         fin_need = 3'd2;
      end else if (fin_value < 21'h10000) begin
         fin_need = 3'd3;
      end else begin
         fin_need = 3'd4;
      end
      fin_ok = !(fin_value inside {[21'hD800:21'hDFFF]}) && (fin_need == state.seq_length);
   end

   // Only one well-formed character per step, so one classifier serves both paths
   assign cls_cp    = (state.bytes_pending != 2'd0 && cont_byte) ? fin_value
                                                                 : {13'd0, byte_value};
   assign cls_start = ident_start_f(cls_cp);
   assign cls_cont  = ident_cont_f(cls_cp);

   always_comb begin
      err_res = '0;

      lead_res = '0;
      if (lead_ok) begin
         lead_res.code_point     = cls_cp;
         lead_res.valid_res      = 1'b1;
         lead_res.ident_start    = cls_start;
         lead_res.ident_continue = cls_cont;
      end

      fin_res = '0;
      if (fin_ok) begin
         fin_res.code_point     = cls_cp;
         fin_res.valid_res      = 1'b1;
         fin_res.ident_start    = cls_start;
         fin_res.ident_continue = cls_cont;
      end
   end

   always_comb begin
      state_next = state;
      res_count  = 2'd0;
      res0       = '0;
      res1       = '0;
      if (op == OP_END) begin
         // cut-off sequence reports one error; always clear everything
         res_count  = (state.bytes_pending != 2'd0) ? 2'd1 : 2'd0;
         res0       = err_res;
         state_next = '0;
      end else if (state.bytes_pending != 2'd0) begin
         if (cont_byte) begin
            state_next.value_accum   = fin_value;
            state_next.bytes_pending = state.bytes_pending - 2'd1;
            if (state.bytes_pending == 2'd1) begin
               res_count  = 2'd1;
               res0       = fin_res;
               state_next = '0;
            end
         end else begin
            // broken continuation: report, drop the sequence, retry as a lead
            res0       = err_res;
            res1       = lead_res;
            res_count  = lead_emit ? 2'd2 : 2'd1;
            state_next = lead_state;
         end
      end else if (state.skipping && !start_byte) begin
         state_next = state;
      end else begin
         res0       = lead_res;
         res_count  = lead_emit ? 2'd1 : 2'd0;
         state_next = lead_state;
      end

      if (res_count == 2'd1) begin
         res0.last = 1'b1;
      end
      if (res_count == 2'd2) begin
         res1.last = 1'b1;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/u8d_rsp_fifo.sv
// Response queue: takes up to two results per cycle, hands out one per cycle while rsp is ready.
`default_nettype none

module u8d_rsp_fifo import u8d_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] wr_count,
   input  rsp_type    wr_data0,
   input  rsp_type    wr_data1,
   output logic       room,
   u8d_rsp_if.source  rsp_if
);

   rsp_type    mem_ff [RSP_DEPTH];
   logic [1:0] wr_ptr_ff;
   logic [1:0] wr_ptr_in;
   logic [1:0] rd_ptr_ff;
   logic [1:0] rd_ptr_in;
   logic [2:0] count_ff;
   logic [2:0] count_in;
   logic [1:0] wr_ptr_p1;
   logic       rd_take;

   assign rd_take   = rsp_if.valid && rsp_if.ready;
   assign wr_ptr_p1 = wr_ptr_ff + 2'd1;
   assign room      = count_ff <= 3'(RSP_DEPTH - 2);

   assign wr_ptr_in = wr_ptr_ff + wr_count;
   assign rd_ptr_in = rd_ptr_ff + {1'b0, rd_take};
   assign count_in  = count_ff + {1'b0, wr_count} - {2'b00, rd_take};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= wr_data0;
      end
      if (wr_count == 2'd2) begin
         mem_ff[wr_ptr_p1] <= wr_data1;
      end
   end

   assign rsp_if.valid          = count_ff != 3'd0;
   assign rsp_if.code_point     = mem_ff[rd_ptr_ff].code_point;
   assign rsp_if.valid_res      = mem_ff[rd_ptr_ff].valid_res;
   assign rsp_if.ident_start    = mem_ff[rd_ptr_ff].ident_start;
   assign rsp_if.ident_continue = mem_ff[rd_ptr_ff].ident_continue;
   assign rsp_if.last           = mem_ff[rd_ptr_ff].last;

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// Testbench: directed and random byte streams through the UTF-8 decoder, checked per result.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import u8d_pkg::*;

   localparam int LIMIT_CYCLES = 200000;  // far above the slowest correct run
   localparam int TAIL_CYCLES  = 20;      // settle time after the last result
   localparam int ITEM_TARGET  = 1725;    // directed plus random byte transactions
   localparam int IDLE_PCT     = 13;
   localparam int CALM_FROM    = 500;     // cycle window with no idling on either side
   localparam int CALM_TO      = 1000;

   // Identifier-continue ranges above ASCII; the planes rule is applied separately.
   localparam int ID_RANGES = 31;
   localparam logic [20:0] ID_LO [ID_RANGES] = '{
      21'h000A8, 21'h000AA, 21'h000AD, 21'h000AF, 21'h000B2, 21'h000B7, 21'h000BC,
      21'h000C0, 21'h000D8, 21'h000F8, 21'h00100, 21'h01681, 21'h0180F, 21'h0200B,
      21'h0202A, 21'h0203F, 21'h02054, 21'h02060, 21'h02070, 21'h02460, 21'h02776,
      21'h02C00, 21'h02E80, 21'h03004, 21'h03021, 21'h03031, 21'h03040, 21'h0F900,
      21'h0FD40, 21'h0FDF0, 21'h0FE47
   };
   localparam logic [20:0] ID_HI [ID_RANGES] = '{
      21'h000A8, 21'h000AA, 21'h000AD, 21'h000AF, 21'h000B5, 21'h000BA, 21'h000BE,
      21'h000D6, 21'h000F6, 21'h000FF, 21'h0167F, 21'h0180D, 21'h01FFF, 21'h0200D,
      21'h0202E, 21'h02040, 21'h02054, 21'h0206F, 21'h0218F, 21'h024FF, 21'h02793,
      21'h02DFF, 21'h02FFF, 21'h03007, 21'h0302F, 21'h0303F, 21'h0D7FF, 21'h0FD3D,
      21'h0FDCF, 21'h0FE44, 21'h0FFF8
   };

   typedef struct {
      logic       op;
      logic [7:0] byte_value;
      bit         drain_first;  // hold this byte until every expected character is out
   } stream_item_type;

   logic clock;
   logic reset;

   u8d_req_if req_ch ();
   u8d_rsp_if rsp_ch ();

   utf8_decode_ident_classify dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   stream_item_type byte_queue [$];      // bytes waiting to be offered
   rsp_type         expected_chars [$];  // decoded characters still owed by the block
   stream_item_type next_item;
   rsp_type         got_char;
   rsp_type         want_char;
   bit              drain_next = 1'b0;
   int              cycle_count = 0;
   int              mismatches = 0;

   // Decoder state mirrored by the predictor.
   logic [1:0]  cont_left = '0;   // continuation bytes still owed
   logic [2:0]  seq_bytes = '0;   // length of the sequence being gathered
   logic [20:0] cp_accum  = '0;   // code point bits gathered so far
   bit          skip_mode = 1'b0; // dropping non-start bytes after a bad lead
   int          results_now;

   // ---------------------------------------------------------------- clock and reset
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      clock               = 1'b0;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.op           = OP_DATA;
      req_ch.byte_value   = 8'h00;
      rsp_ch.ready        = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------- identifier classes
   function automatic bit id_continue_class(logic [20:0] c);
      bit hit;
      hit = 1'b0;
      if (c < 21'h80) begin
         // ASCII letters, digits, underscore and dollar
         return (c >= 21'h61 && c <= 21'h7A) || (c >= 21'h41 && c <= 21'h5A) ||
                (c >= 21'h30 && c <= 21'h39) || c == 21'h5F || c == 21'h24;
      end
      for (int i = 0; i < ID_RANGES; i++) begin
         if (c >= ID_LO[i] && c <= ID_HI[i]) hit = 1'b1;
      end
      // Planes 1 to 14 count, except the last two code points of each plane.
      if (c >= 21'h10000 && c <= 21'hEFFFD && c[15:0] <= 16'hFFFD) hit = 1'b1;
      return hit;
   endfunction

   function automatic bit id_start_class(logic [20:0] c);
      if (!id_continue_class(c)) return 1'b0;
      // Digits and dollar may continue but never begin an identifier.
      if ((c >= 21'h30 && c <= 21'h39) || c == 21'h24) return 1'b0;
      // Combining marks likewise.
      if ((c >= 21'h0300 && c <= 21'h036F) || (c >= 21'h1DC0 && c <= 21'h1DFF) ||
          (c >= 21'h20D0 && c <= 21'h20FF) || (c >= 21'hFE20 && c <= 21'hFE2F)) begin
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------- predictor
   // Start bytes: ASCII and 0xC2..0xF4. Note 0x80 is not one.
   function automatic bit starts_char(logic [7:0] b);
      return b < 8'h80 || (b >= 8'hC2 && b < 8'hF5);
   endfunction

   // Queue one decoded character; errors carry a zero code point and no classes.
   task automatic note_char(bit ok, logic [20:0] cp);
      rsp_type r;
      r.code_point     = ok ? cp : '0;
      r.valid_res      = ok;
      r.ident_start    = ok && id_start_class(cp);
      r.ident_continue = ok && id_continue_class(cp);
      r.last           = 1'b0;
      expected_chars.push_back(r);
      results_now++;
   endtask

   task automatic drop_seq();
      cont_left = '0;
      seq_bytes = '0;
      cp_accum  = '0;
   endtask

   // Decode a byte seen outside a sequence.
   task automatic open_char(logic [7:0] b);
      logic [2:0] n;
      if (b < 8'h80) begin
         note_char(1'b1, {13'b0, b});
      end else if (!starts_char(b)) begin
         // bad lead: report once, then resync on the next start byte
         note_char(1'b0, '0);
         skip_mode = 1'b1;
      end else begin
         if (b[7:5] == 3'b110) begin
            n = 3'd2;
         end else if (b[7:4] == 4'b1110) begin
            n = 3'd3;
         end else begin
            n = 3'd4;
         end
         seq_bytes = n;
         cont_left = 2'(n - 3'd1);
         cp_accum  = {13'b0, b & (8'hFF >> (n + 3'd1))};
      end
   endtask

   // A full sequence is in: reject surrogates and overlong forms.
   task automatic close_char();
      logic [20:0] v;
      logic [2:0]  need;
      bit          ok;
      v    = cp_accum;
      need = (v < 21'h800) ? 3'd2 : ((v < 21'h10000) ? 3'd3 : 3'd4);
      ok   = !(v >= 21'hD800 && v <= 21'hDFFF) && need == seq_bytes;
      note_char(ok, v);
      drop_seq();
   endtask

   task automatic decode_transaction(logic op, logic [7:0] b);
      results_now = 0;
      if (op == OP_END) begin
         // end of stream: a cut-off sequence is an error; all state clears
         if (cont_left != 0) note_char(1'b0, '0);
         drop_seq();
         skip_mode = 1'b0;
      end else if (cont_left != 0) begin
         if (b[7:6] == 2'b10) begin
            cp_accum  = {cp_accum[14:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 0) close_char();
         end else begin
            // broken continuation: flag it, then restart on the same byte
            note_char(1'b0, '0);
            drop_seq();
            open_char(b);
         end
      end else if (skip_mode) begin
         if (starts_char(b)) begin
            skip_mode = 1'b0;
            open_char(b);
         end
      end else begin
         open_char(b);
      end
      if (results_now > 0) expected_chars[expected_chars.size() - 1].last = 1'b1;
   endtask

   // ---------------------------------------------------------------- stimulus helpers
   function automatic bit take_break();
      if (cycle_count >= CALM_FROM && cycle_count < CALM_TO) return 1'b0;
      return $urandom_range(0, 99) < IDLE_PCT;
   endfunction

   function automatic int min_len(logic [20:0] cp);
      return (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
   endfunction

   // Mix of class-table edges, plane ends and plain random values per length.
   function automatic logic [20:0] pick_code_point();
      int sel;
      int k;
      sel = $urandom_range(0, 9);
      k   = $urandom_range(0, ID_RANGES - 1);
      if (sel < 3) begin
         if ($urandom_range(0, 1)) return ID_LO[k] - 21'd1 + 21'($urandom_range(0, 1));
         return ID_HI[k] + 21'($urandom_range(0, 1));
      end
      if (sel == 3) return {5'($urandom_range(1, 19)), 16'hFFFC + 16'($urandom_range(0, 3))};
      if (sel < 6) return 21'($urandom_range(0, 'h7F));
      if (sel == 6) return 21'($urandom_range('h80, 'h7FF));
      if (sel < 9) return 21'($urandom_range('h800, 'hFFFF));
      return 21'($urandom_range('h10000, 'h13FFFF));
   endfunction

   task automatic push_item(logic op, logic [7:0] b);
      stream_item_type it;
      it.op          = op;
      it.byte_value  = b;
      it.drain_first = drain_next;
      drain_next     = 1'b0;
      byte_queue.push_back(it);
   endtask

   // Encode cp in len bytes (longer than needed gives an overlong form); push the first keep.
   task automatic push_char(logic [20:0] cp, int len, int keep);
      logic [7:0] enc [4];
      enc = '{default: 8'h00};
      case (len)
         1: enc[0] = cp[7:0];
         2: begin
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
         end
         3: begin
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
         end
         default: begin
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
         end
      endcase
      for (int i = 0; i < keep; i++) push_item(OP_DATA, enc[i]);
   endtask

   // ---------------------------------------------------------------- stimulus and end of run
   initial begin : stimulus
      int          pick;
      int          len;
      logic [20:0] cp;

      // Directed: ASCII extremes, shortest and longest multi-byte forms.
      push_item(OP_DATA, 8'h00);
      push_item(OP_DATA, 8'h7F);
      push_char(21'h00080, 2, 2);
      push_char(21'h007FF, 3, 3);    // overlong
      push_char(21'h0D800, 3, 3);    // surrogate
      push_char(21'h13FFFF, 4, 4);   // largest value a 0xF4 lead can carry
      // Bad lead 0x80, then non-start bytes that are dropped, then a resync.
      push_item(OP_DATA, 8'h80);
      push_item(OP_DATA, 8'hBF);
      push_item(OP_DATA, 8'hFF);
      push_item(OP_DATA, 8'h41);
      // Broken continuation: error plus the letter decoded as a fresh lead.
      push_char(21'h02000, 3, 1);
      push_item(OP_DATA, 8'h41);
      // Cut-off sequence at end of stream, then a bare end.
      push_char(21'h10000, 4, 1);
      push_item(OP_END, 8'hA5);
      push_item(OP_END, 8'h5A);

      // Random: mostly well-formed characters, the rest malformed or noise.
      drain_next = 1'b1;
      while (byte_queue.size() < ITEM_TARGET) begin
         if ($urandom_range(0, 199) == 0) drain_next = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            cp = pick_code_point();
            push_char(cp, min_len(cp), min_len(cp));
         end else if (pick < 63) begin
            cp  = $urandom_range(0, 1) ? 21'($urandom_range(0, 'h7FF))
                                       : 21'($urandom_range(0, 'hFFFF));
            len = min_len(cp);
            if (len < 4) len = $urandom_range(len + 1, 4);
            push_char(cp, len, len);
         end else if (pick < 73) begin
            // truncate, so the next byte or an end breaks the sequence
            cp  = pick_code_point();
            len = min_len(cp);
            push_char(cp, len, (len > 1) ? $urandom_range(1, len - 1) : 1);
         end else if (pick < 81) begin
            push_item(OP_END, 8'($urandom_range(0, 255)));
         end else if (pick < 91) begin
            push_item(OP_DATA, 8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 3)) push_item(OP_DATA, 8'h80 | 8'($urandom_range(0, 63)));
         end
      end

      // Drain: every byte taken, every character seen, then a short settle.
      while (byte_queue.size() != 0 || req_ch.valid) @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // ---------------------------------------------------------------- byte driver
   // Predict on acceptance, then offer the next byte unless idling or holding for a drain.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            decode_transaction(req_ch.op, req_ch.byte_value);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (byte_queue.size() != 0 &&
                !(byte_queue[0].drain_first && expected_chars.size() != 0) &&
                !take_break()) begin
               next_item = byte_queue.pop_front();
               req_ch.valid      <= 1'b1;
               req_ch.op         <= next_item.op;
               req_ch.byte_value <= next_item.byte_value;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- result monitor
   task automatic check_field(string tag, logic [20:0] want, logic [20:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, tag, want, got);
      end
   endtask

   // Pop the oldest expected character on each transaction and compare every field.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_char.code_point     = rsp_ch.code_point;
            got_char.valid_res      = rsp_ch.valid_res;
            got_char.ident_start    = rsp_ch.ident_start;
            got_char.ident_continue = rsp_ch.ident_continue;
            got_char.last           = rsp_ch.last;
            if (expected_chars.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result, expected none, actual cp %0h valid %0b",
                        $time, got_char.code_point, got_char.valid_res);
            end else begin
               want_char = expected_chars.pop_front();
               check_field("code_point", want_char.code_point, got_char.code_point);
               check_field("valid_res", 21'(want_char.valid_res), 21'(got_char.valid_res));
               check_field("ident_start", 21'(want_char.ident_start), 21'(got_char.ident_start));
               check_field("ident_continue", 21'(want_char.ident_continue),
                           21'(got_char.ident_continue));
               check_field("last", 21'(want_char.last), 21'(got_char.last));
            end
         end
         rsp_ch.ready <= !take_break();
      end
   end

   // ---------------------------------------------------------------- watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

endmodule

`default_nettype wire

FILE: sim.f
rtl/u8d_pkg.sv
rtl/u8d_if.sv
rtl/u8d_decode.sv
rtl/u8d_rsp_fifo.sv
rtl/utf8_decode_ident_classify.sv
verif/tb_top.sv
